@@ sv/rgba16_unpremultiply_to_rgba8_assert.svh @@
// assertion macros for the rgba16 unpremultiply block checker
// expects signals aclk and aresetn in the scope of each use
`ifndef RGBA16_UNPREMULTIPLY_TO_RGBA8_ASSERT_SVH
`define RGBA16_UNPREMULTIPLY_TO_RGBA8_ASSERT_SVH

// checked outside reset only
`define RGBU_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("rgbu checker: property failed");

// checked also while reset is held
`define RGBU_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("rgbu checker: reset property failed");

`endif

@@ sv/rgbu_pkg.sv @@
// shared types, constants and helpers of the rgba16 unpremultiply block
// no dependencies
`default_nettype none

package rgbu_pkg;

    localparam int CH_W        = 16;
    localparam int OUT_W       = 8;
    localparam int NUM_LANES   = 3;
    localparam int NUM_CH      = NUM_LANES + 1;
    localparam int DATA_IN_W   = CH_W * NUM_CH;
    localparam int DATA_OUT_W  = OUT_W * NUM_CH;
    localparam int PROD_W      = 2 * CH_W;
    localparam int QUO_W       = OUT_W;
    localparam int PRE_SHIFT   = 8;
    localparam int LANE_STAGES = QUO_W + 1;
    localparam int FMT_W       = 2;

    localparam logic [OUT_W-1:0] SAT_MAX = '1;

    typedef enum logic [FMT_W-1:0] {
        FMT_RGBA8_STRAIGHT  = 2'd0,
        FMT_RGBA16_PREMUL   = 2'd1,
        FMT_RGBA16_STRAIGHT = 2'd2
    } fmt_t;

    // pipeline control from the top level
    typedef struct packed {
        logic advance;
        logic out_load;
        logic out_sel_skid;
        logic skid_load;
    } pipe_ctl_t;

    // what one lane hands to the merge stage
    typedef struct packed {
        logic [QUO_W-1:0] quo;
        logic             sat;
        logic             zero;
        logic [OUT_W-1:0] pass;
    } lane_res_t;

    // per-pixel sideband that rides beside the lanes
    typedef struct packed {
        logic [FMT_W-1:0] fmt;
        logic [OUT_W-1:0] alpha;
    } side_t;

    // byte taken straight from a channel: low byte for 8-bit, high byte for 16-bit
    function automatic logic [OUT_W-1:0] pass_byte(input logic [FMT_W-1:0] fmt,
                                                   input logic [CH_W-1:0]  c);
        logic [OUT_W-1:0] b;
        case (fmt)
            FMT_RGBA8_STRAIGHT:  b = c[OUT_W-1:0];
            FMT_RGBA16_PREMUL:   b = c[CH_W-1:CH_W-OUT_W];
            FMT_RGBA16_STRAIGHT: b = c[CH_W-1:CH_W-OUT_W];
            default:             b = '0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ sv/rgba16_unpremultiply_to_rgba8.sv @@
// top level of the rgba16 unpremultiply block: config register, pipeline control, lanes
// depends on rgbu_pkg, rgbu_lane, rgbu_merge
//
// converts one pixel per request into 8-bit straight rgba
// - s_ channel: one pixel per request, four 16-bit channels in s_tdata
// - m_ channel: one 8-bit rgba pixel per request in m_tdata
// - cfg channel: writes source_format (0 rgba8 straight, 1 rgba16 premultiplied,
//   2 rgba16 straight, 3 gives an all-zero pixel); cfg_ready is always high,
//   write only while no pixel is in flight
// - premultiplied colour: min((c * 65535 / alpha) >> 8, 255), black at zero alpha
// - path: the entry stage loads the accepted pixel, then 8 divide stages of one
//   quotient bit each follow, then the merge register drives m_tvalid
// - throughput: one pixel per cycle while s_tready is high, every divide step is its own register stage
// - receiver stall: the merge output register holds, a one-entry skid register
//   catches the pixel leaving the lanes; s_tready drops only while the skid is full
// - reset: synchronous on aresetn low, clears all valid flags and sets
//   source_format to rgba16 premultiplied; payload registers are not reset
`default_nettype none

module rgba16_unpremultiply_to_rgba8 (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // slave side: red [15:0], green [31:16], blue [47:32], alpha [63:48]
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [rgbu_pkg::DATA_IN_W-1:0]      s_tdata,
    // master side: red [7:0], green [15:8], blue [23:16], alpha [31:24]
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [rgbu_pkg::DATA_OUT_W-1:0]          m_tdata,
    // config write: source_format
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rgbu_pkg::FMT_W-1:0]          cfg_data
);

    // source format register
    logic [rgbu_pkg::FMT_W-1:0] src_fmt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_fmt_reg <= rgbu_pkg::FMT_RGBA16_PREMUL;
        end else if (cfg_valid && cfg_ready) begin
            src_fmt_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    // pipeline control: all lane stages shift together while the skid is empty
    logic [rgbu_pkg::LANE_STAGES-1:0] valid_reg;
    logic [rgbu_pkg::LANE_STAGES-1:0] valid_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             skid_valid_reg;
    logic                             skid_valid_next;
    logic                             out_free;
    logic                             arriving;
    rgbu_pkg::pipe_ctl_t              ctl;

    assign s_tready = !skid_valid_reg;
    assign out_free = !out_valid_reg || m_tready;
    // lanes shift exactly when the skid is empty
    assign arriving = !skid_valid_reg && valid_reg[rgbu_pkg::LANE_STAGES-1];

    always_comb begin
        ctl.advance      = !skid_valid_reg;
        ctl.out_sel_skid = skid_valid_reg;
        ctl.out_load     = out_free && (skid_valid_reg || arriving);
        ctl.skid_load    = !out_free && arriving;
    end

    always_comb begin
        valid_next = valid_reg;
        if (ctl.advance) begin
            valid_next = {valid_reg[rgbu_pkg::LANE_STAGES-2:0], s_tvalid};
        end
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free) begin
            // skid drains first; it is never loaded in the same cycle
            out_valid_next  = skid_valid_reg || arriving;
            skid_valid_next = 1'b0;
        end else if (arriving) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    // sideband line: format and output alpha beside the lanes
    logic [rgbu_pkg::CH_W-1:0] alpha_in;
    rgbu_pkg::side_t           side_reg  [rgbu_pkg::LANE_STAGES];
    rgbu_pkg::side_t           side_next [rgbu_pkg::LANE_STAGES];

    assign alpha_in = s_tdata[rgbu_pkg::CH_W*rgbu_pkg::NUM_LANES +: rgbu_pkg::CH_W];

    // alpha is the high byte in both 16-bit modes, low byte in 8-bit mode
    assign side_next[0] = '{fmt:   src_fmt_reg,
                            alpha: rgbu_pkg::pass_byte(src_fmt_reg, alpha_in)};

    for (genvar k = 1; k < rgbu_pkg::LANE_STAGES; k++) begin : g_side
        assign side_next[k] = side_reg[k-1];
    end

    for (genvar k = 0; k < rgbu_pkg::LANE_STAGES; k++) begin : g_side_reg
        always_ff @(posedge aclk) begin
            if (ctl.advance) begin
                side_reg[k] <= side_next[k];
            end
        end
    end

    // three colour lanes
    rgbu_pkg::lane_res_t lane_res [rgbu_pkg::NUM_LANES];

    for (genvar i = 0; i < rgbu_pkg::NUM_LANES; i++) begin : g_lane
        rgbu_lane u_lane (
            .aclk   (aclk),
            .ctl    (ctl),
            .c_in   (s_tdata[rgbu_pkg::CH_W*i +: rgbu_pkg::CH_W]),
            .a_in   (alpha_in),
            .fmt_in (src_fmt_reg),
            .res    (lane_res[i])
        );
    end

    // merge, output register and skid
    rgbu_merge u_merge (
        .aclk    (aclk),
        .ctl     (ctl),
        .lanes   (lane_res),
        .side    (side_reg[rgbu_pkg::LANE_STAGES-1]),
        .pix_out (m_tdata)
    );

endmodule

`default_nettype wire

@@ sv/rgbu_lane.sv @@
// one colour lane: scale by 65535 and divide by 256*alpha, one quotient bit a stage
// depends on rgbu_pkg
`default_nettype none

module rgbu_lane (
    input  wire logic                          aclk,
    input  wire rgbu_pkg::pipe_ctl_t           ctl,
    input  wire logic [rgbu_pkg::CH_W-1:0]     c_in,
    input  wire logic [rgbu_pkg::CH_W-1:0]     a_in,
    input  wire logic [rgbu_pkg::FMT_W-1:0]    fmt_in,
    output rgbu_pkg::lane_res_t                res
);

    typedef struct packed {
        logic [rgbu_pkg::PROD_W-1:0] rem;
        logic [rgbu_pkg::CH_W-1:0]   a;
        logic [rgbu_pkg::QUO_W-1:0]  quo;
        logic                        sat;
        logic                        zero;
        logic [rgbu_pkg::OUT_W-1:0]  pass;
    } stage_t;

    stage_t st_reg  [rgbu_pkg::LANE_STAGES];
    stage_t st_next [rgbu_pkg::LANE_STAGES];

    logic [rgbu_pkg::PROD_W-1:0] prod;

    // c * 65535 as (c << 16) - c
    assign prod = {c_in, {rgbu_pkg::CH_W{1'b0}}} - {{rgbu_pkg::CH_W{1'b0}}, c_in};

    // colour above alpha always saturates, so the quotient fits in QUO_W bits otherwise
    assign st_next[0] = '{rem:  prod,
                          a:    a_in,
                          quo:  '0,
                          sat:  (c_in > a_in),
                          zero: (a_in == '0),
                          pass: rgbu_pkg::pass_byte(fmt_in, c_in)};

    always_ff @(posedge aclk) begin
        if (ctl.advance) begin
            st_reg[0] <= st_next[0];
        end
    end

    for (genvar k = 1; k < rgbu_pkg::LANE_STAGES; k++) begin : g_step
        localparam int SH = rgbu_pkg::PRE_SHIFT + rgbu_pkg::QUO_W - k;

        logic [rgbu_pkg::PROD_W-1:0] div;
        logic                        ge;

        assign div = {{rgbu_pkg::CH_W{1'b0}}, st_reg[k-1].a} << SH;
        assign ge  = (st_reg[k-1].rem >= div);

        assign st_next[k] = '{rem:  ge ? (st_reg[k-1].rem - div) : st_reg[k-1].rem,
                              a:    st_reg[k-1].a,
                              quo:  {st_reg[k-1].quo[rgbu_pkg::QUO_W-2:0], ge},
                              sat:  st_reg[k-1].sat,
                              zero: st_reg[k-1].zero,
                              pass: st_reg[k-1].pass};

        always_ff @(posedge aclk) begin
            if (ctl.advance) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign res = '{quo:  st_reg[rgbu_pkg::LANE_STAGES-1].quo,
                   sat:  st_reg[rgbu_pkg::LANE_STAGES-1].sat,
                   zero: st_reg[rgbu_pkg::LANE_STAGES-1].zero,
                   pass: st_reg[rgbu_pkg::LANE_STAGES-1].pass};

endmodule

`default_nettype wire

@@ sv/rgbu_merge.sv @@
// merge stage: picks each lane's byte by format, packs the pixel, output and skid registers
// depends on rgbu_pkg
`default_nettype none

module rgbu_merge (
    input  wire logic                                aclk,
    input  wire rgbu_pkg::pipe_ctl_t                 ctl,
    input  wire rgbu_pkg::lane_res_t                 lanes [rgbu_pkg::NUM_LANES],
    input  wire rgbu_pkg::side_t                     side,
    output logic [rgbu_pkg::DATA_OUT_W-1:0]          pix_out
);

    logic [rgbu_pkg::DATA_OUT_W-1:0] pix_next;
    logic [rgbu_pkg::DATA_OUT_W-1:0] out_reg;
    logic [rgbu_pkg::DATA_OUT_W-1:0] out_next;
    logic [rgbu_pkg::DATA_OUT_W-1:0] skid_reg;

    always_comb begin
        pix_next = '0;
        for (int i = 0; i < rgbu_pkg::NUM_LANES; i++) begin
            if (side.fmt == rgbu_pkg::FMT_RGBA16_PREMUL) begin
                if (lanes[i].zero) begin
                    pix_next[rgbu_pkg::OUT_W*i +: rgbu_pkg::OUT_W] = '0;
                end else if (lanes[i].sat) begin
                    pix_next[rgbu_pkg::OUT_W*i +: rgbu_pkg::OUT_W] = rgbu_pkg::SAT_MAX;
                end else begin
                    pix_next[rgbu_pkg::OUT_W*i +: rgbu_pkg::OUT_W] = lanes[i].quo;
                end
            end else begin
                pix_next[rgbu_pkg::OUT_W*i +: rgbu_pkg::OUT_W] = lanes[i].pass;
            end
        end
        pix_next[rgbu_pkg::OUT_W*rgbu_pkg::NUM_LANES +: rgbu_pkg::OUT_W] = side.alpha;
    end

    assign out_next = ctl.out_sel_skid ? skid_reg : pix_next;

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            out_reg <= out_next;
        end
        if (ctl.skid_load) begin
            skid_reg <= pix_next;
        end
    end

    assign pix_out = out_reg;

endmodule

`default_nettype wire

@@ sv/rgbu_checker.sv @@
// port-level checker for the rgba16 unpremultiply block, bound to the top level
// depends on rgbu_pkg and rgba16_unpremultiply_to_rgba8_assert.svh
`default_nettype none

`include "rgba16_unpremultiply_to_rgba8_assert.svh"

module rgbu_port_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_tready,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [rgbu_pkg::DATA_OUT_W-1:0]     m_tdata
);

    // reset empties the output side
    `RGBU_ASSERT_RST(a_reset_clears_out, !aresetn |=> !m_tvalid)

    // input only backs up when a finished pixel is waiting at the output
    `RGBU_ASSERT(a_stall_has_out, !s_tready |-> m_tvalid)

    // a stalled request keeps valid and data
    `RGBU_ASSERT(a_out_valid_holds, m_tvalid && !m_tready |=> m_tvalid)
    `RGBU_ASSERT(a_out_data_holds, m_tvalid && !m_tready |=> $stable(m_tdata))

endmodule

bind rgba16_unpremultiply_to_rgba8 rgbu_port_checker u_rgbu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ bench/rgbu_checker.sv @@
// pixel checker for the rgba16 unpremultiply block: follows source_format writes,
// predicts every 8-bit result pixel and compares it with the m_ channel
// depends on rgbu_pkg
module rgbu_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [rgbu_pkg::DATA_IN_W-1:0]     s_tdata,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [rgbu_pkg::DATA_OUT_W-1:0]    m_tdata,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [rgbu_pkg::FMT_W-1:0]         cfg_data,
    output int                                 fail_count,
    output int                                 pixels_pending
);
    import rgbu_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // red in the lowest byte, as on m_tdata
    typedef struct packed {
        logic [OUT_W-1:0] alpha;
        logic [OUT_W-1:0] blue;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] red;
    } rgba8_t;

    logic [FMT_W-1:0] active_format = FMT_RGBA16_PREMUL;
    rgba8_t           expected_pixels[$];

    function automatic logic [OUT_W-1:0] unpremultiply_channel(input logic [CH_W-1:0] c,
                                                               input logic [CH_W-1:0] a);
        logic [31:0] quotient;
        if (a == '0)
            return '0;
        quotient = ({16'd0, c} * 32'd65535) / {16'd0, a};
        quotient = quotient >> 8;
        return (quotient > 32'd255) ? 8'hFF : quotient[OUT_W-1:0];
    endfunction

    function automatic rgba8_t predict_pixel(input logic [FMT_W-1:0]     fmt,
                                             input logic [DATA_IN_W-1:0] px);
        rgba8_t          p;
        logic [CH_W-1:0] r, g, b, a;
        r = px[0*CH_W +: CH_W];
        g = px[1*CH_W +: CH_W];
        b = px[2*CH_W +: CH_W];
        a = px[3*CH_W +: CH_W];
        p = '0;
        case (fmt)
            FMT_RGBA8_STRAIGHT: begin
                p.red   = r[7:0];
                p.green = g[7:0];
                p.blue  = b[7:0];
                p.alpha = a[7:0];
            end
            FMT_RGBA16_PREMUL: begin
                p.red   = unpremultiply_channel(r, a);
                p.green = unpremultiply_channel(g, a);
                p.blue  = unpremultiply_channel(b, a);
                p.alpha = a[15:8];
            end
            FMT_RGBA16_STRAIGHT: begin
                p.red   = r[15:8];
                p.green = g[15:8];
                p.blue  = b[15:8];
                p.alpha = a[15:8];
            end
            default: p = '0;
        endcase
        return p;
    endfunction

    always @(posedge aclk) begin : watch
        rgba8_t got;
        rgba8_t want;
        if (!aresetn) begin
            active_format = FMT_RGBA16_PREMUL;
            expected_pixels.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_pixels.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("[%0t] unexpected pixel r=%h g=%h b=%h a=%h", $realtime,
                                 got.red, got.green, got.blue, got.alpha);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.alpha !== want.alpha) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("[%0t] pixel mismatch: expected %h, got %h (abgr)",
                                     $realtime, want, got);
                    end
                end
            end
            // the format in force before this edge applies to a pixel taken at it
            if (s_tvalid && s_tready)
                expected_pixels.push_back(predict_pixel(active_format, s_tdata));
            if (cfg_valid && cfg_ready)
                active_format = cfg_data;
        end
        pixels_pending = expected_pixels.size();
    end

endmodule

@@ bench/tb_rgba16_unpremultiply_to_rgba8.sv @@
// testbench top for rgba16_unpremultiply_to_rgba8: clock, reset, pixel stimulus,
// source_format writes between phases and the final verdict
// depends on rgbu_pkg, rgbu_checker and the block itself
module tb_rgba16_unpremultiply_to_rgba8;
    import rgbu_pkg::*;

    localparam int PIPE_LATENCY = 9;       // accept edge to m_tvalid
    localparam int CYCLE_LIMIT  = 300000;  // far above the slowest legal run
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_PIXELS = 210;

    // format code with no meaning, the block gives an all-zero pixel
    localparam logic [FMT_W-1:0] FMT_UNUSED = 2'd3;

    // red in the lowest 16 bits, as on s_tdata
    typedef struct packed {
        logic [CH_W-1:0] alpha;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgba16_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_IN_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_OUT_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [FMT_W-1:0]      cfg_data  = '0;

    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int               cycle_count    = 0;
    int               fail_count;
    int               pixels_pending;
    logic [FMT_W-1:0] current_format = FMT_RGBA16_PREMUL;

    always #4 aclk = ~aclk;

    // receiver: stalls decided fresh at every falling edge
    always @(negedge aclk)
        m_tready = ($urandom_range(99) >= recv_stall_pct);

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    rgba16_unpremultiply_to_rgba8 uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    rgbu_checker pixel_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pixels_pending (pixels_pending)
    );

    function automatic rgba16_t make_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                           input logic [CH_W-1:0] b, input logic [CH_W-1:0] a);
        rgba16_t p;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        p.alpha = a;
        return p;
    endfunction

    // premultiplied colour is normally at most alpha; a quarter is drawn from the full range and may go above it
    function automatic logic [CH_W-1:0] random_colour(input logic [CH_W-1:0] a);
        if ($urandom_range(99) < 75)
            return CH_W'($urandom_range(int'(a), 0));
        return CH_W'($urandom_range(65535, 0));
    endfunction

    function automatic rgba16_t random_pixel(input logic [FMT_W-1:0] fmt);
        rgba16_t     p;
        int unsigned pick;
        p = {$urandom, $urandom};
        if (fmt == FMT_RGBA16_PREMUL) begin
            pick = $urandom_range(99);
            if (pick < 4)
                p.alpha = '0;
            else if (pick < 20)
                p.alpha = CH_W'($urandom_range(255, 1));
            p.red   = random_colour(p.alpha);
            p.green = random_colour(p.alpha);
            p.blue  = random_colour(p.alpha);
        end
        return p;
    endfunction

    // called at a falling edge, returns at the falling edge after the request
    task automatic send_pixel(input rgba16_t px);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = px;
        do
            @(posedge aclk);
        while (!s_tready);
        @(negedge aclk);
    endtask

    // sender holds off until every pixel in flight has come out
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pixels_pending != 0)
            @(negedge aclk);
    endtask

    // format changes only with the pipeline empty
    task automatic write_format(input logic [FMT_W-1:0] fmt);
        wait_drained();
        repeat (PIPE_LATENCY) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = fmt;
        do
            @(posedge aclk);
        while (!cfg_ready);
        @(negedge aclk);
        cfg_valid      = 1'b0;
        current_format = fmt;
    endtask

    function automatic logic [FMT_W-1:0] phase_format(input int phase);
        case (phase)
            1:       return FMT_RGBA8_STRAIGHT;
            3:       return FMT_RGBA16_STRAIGHT;
            5:       return FMT_UNUSED;
            6:       return FMT_RGBA16_STRAIGHT;
            default: return FMT_RGBA16_PREMUL;
        endcase
    endfunction

    initial begin : stimulus
        int phase;
        int n;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // premultiplied from reset: black at zero alpha, full scale, saturation
        send_pixel(make_pixel(16'hFFFF, 16'h8000, 16'h0000, 16'h0000));
        send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_pixel(make_pixel(16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
        send_pixel(make_pixel(16'hFFFF, 16'h0100, 16'h0001, 16'h0001));
        send_pixel(make_pixel(16'h0001, 16'h0002, 16'h0080, 16'h0100));
        send_pixel(make_pixel(16'h8000, 16'h4000, 16'h00FF, 16'hFFFF));
        send_pixel(make_pixel(16'h7FFF, 16'h8000, 16'h8001, 16'h8000));
        send_pixel(make_pixel(16'h00FF, 16'h0100, 16'h00FE, 16'h00FF));
        send_pixel(make_pixel(16'h1234, 16'h5678, 16'h9ABC, 16'hFFFE));
        send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));

        // 8-bit straight: only the low bytes count
        write_format(FMT_RGBA8_STRAIGHT);
        send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_pixel(make_pixel(16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0));
        send_pixel(make_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000));

        // 16-bit straight: high bytes
        write_format(FMT_RGBA16_STRAIGHT);
        send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_pixel(make_pixel(16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0));
        send_pixel(make_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000));

        // unused code: everything zero
        write_format(FMT_UNUSED);
        send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_pixel(make_pixel(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0));

        // random phases, each with a format and idling pattern chosen by its phase number
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            write_format(phase_format(phase));
            case (phase % 4)
                1: send_idle_pct = 81;
                2: recv_stall_pct = 81;
                3: begin
                    send_idle_pct  = 14;
                    recv_stall_pct = 14;
                end
                default: ;
            endcase
            for (n = 0; n < PHASE_PIXELS; n++) begin
                // hold off mid-phase until the pipeline is empty
                if (n == PHASE_PIXELS / 2)
                    wait_drained();
                send_pixel(random_pixel(current_format));
            end
        end

        send_idle_pct = 0;
        wait_drained();
        recv_stall_pct = 0;
        repeat (2 * PIPE_LATENCY) @(posedge aclk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
